>>> hdl/trdiv_pkg.sv
// Shared constants and types for the trial division primality tester.
`timescale 1ns / 1ps
package trdiv_pkg;

   localparam int NUMBER_WIDTH_DEF = 20;
   localparam int FIRST_DIVISOR = 2;
   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic advance;
      logic init;
   } ctrl_type;

endpackage

>>> hdl/trial_division_primality_test.sv
// Trial division primality tester: one number in, one prime flag out.
// Numbers below two go from acceptance straight to ST_DONE; other numbers alternate ST_CHECK and
// ST_DIVIDE over the divisors 2, 3, 5, 7, ... (about 2^(NUMBER_WIDTH/2 - 1) of them at most) until
// one divides it or its square exceeds it; each passes the bit-serial remainder unit in ST_DIVIDE.
// One number is in work at a time; the next is taken in ST_IDLE, entered as its result is registered.
// Synchronous active-high reset empties the control state and the output valid flag, not the prime flag.
`timescale 1ns / 1ps
module trial_division_primality_test #(
   parameter int NUMBER_WIDTH = trdiv_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((NUMBER_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // number
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [trdiv_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata   // is_prime
);
   import trdiv_pkg::*;

   state_type               state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] n_ff, n_in;
   logic                    res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_prime_ff, rsp_prime_in;
   ctrl_type                ctrl;
   logic [NUMBER_WIDTH-1:0] divisor;
   logic [NUMBER_WIDTH+1:0] square;
   logic                    rem_done;
   logic                    rem_zero;
   logic                    out_free;

   trdiv_step #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_step (
      .clock   (clock),
      .ctrl    (ctrl),
      .divisor (divisor),
      .square  (square)
   );

   trdiv_rem #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.start),
      .dividend (n_ff),
      .divisor  (divisor),
      .done     (rem_done),
      .rem_zero (rem_zero)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      ctrl         = '0;
      req_tready   = (state_ff == ST_IDLE);
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in      = req_tdata[NUMBER_WIDTH-1:0];
               ctrl.init = 1'b1;
               if (req_tdata[NUMBER_WIDTH-1:1] == '0) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (square > {2'b00, n_ff}) begin
               res_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               ctrl.start = 1'b1;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_done) begin
               if (rem_zero) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  ctrl.advance = 1'b1;
                  state_in     = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      res_ff       <= res_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 1){1'b0}}, rsp_prime_ff};

endmodule

>>> hdl/trdiv_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module trdiv_rem #(
   parameter int NUMBER_WIDTH = trdiv_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic                    done,
   output logic                    rem_zero
);
   import trdiv_pkg::*;

   localparam int CW = $clog2(NUMBER_WIDTH);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;
   logic [NUMBER_WIDTH-1:0] div_ff, div_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   diff;

   assign trial = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[NUMBER_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[NUMBER_WIDTH-1:0];
         end else begin
            rem_in = trial[NUMBER_WIDTH-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUMBER_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

>>> hdl/trdiv_step.sv
// Trial divisor generator that also tracks the divisor squared.
`timescale 1ns / 1ps
module trdiv_step #(
   parameter int NUMBER_WIDTH = trdiv_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  trdiv_pkg::ctrl_type     ctrl,
   output logic [NUMBER_WIDTH-1:0] divisor,
   output logic [NUMBER_WIDTH+1:0] square
);
   import trdiv_pkg::*;

   localparam int SW = NUMBER_WIDTH + 2;

   logic [NUMBER_WIDTH-1:0] d_ff, d_in;
   logic [SW-1:0]           sq_ff, sq_in;

   always_comb begin
      d_in  = d_ff;
      sq_in = sq_ff;
      if (ctrl.init) begin
         d_in  = NUMBER_WIDTH'(FIRST_DIVISOR);
         sq_in = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
      end else if (ctrl.advance) begin
         if (d_ff == NUMBER_WIDTH'(FIRST_DIVISOR)) begin
            d_in  = NUMBER_WIDTH'(FIRST_DIVISOR + 1);
            sq_in = SW'((FIRST_DIVISOR + 1) * (FIRST_DIVISOR + 1));
         end else begin
            // (d + 2)^2 = d^2 + 4d + 4.
            d_in  = d_ff + NUMBER_WIDTH'(2);
            sq_in = sq_ff + {d_ff, 2'b00} + SW'(4);
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      sq_ff <= sq_in;
   end

   assign divisor = d_ff;
   assign square  = sq_ff;

endmodule
